// File: sv/mad_pkg.sv
// Package for the motion alarm controller: mode, command and timer codes,
// register indexes and the period helpers.
// No dependencies; every other file imports it.
package mad_pkg;

    // Field widths
    localparam int CMD_W    = 3;
    localparam int PIN_W    = 4;
    localparam int MODE_W   = 2;
    localparam int OMODE_W  = 3;
    localparam int SEC_W    = 8;
    localparam int COUNT_W  = 18;
    localparam int IDX_W    = 2;
    localparam int CFG_W    = 8;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 8;

    localparam int MS_PER_SECOND = 1000;

    // Operating modes of an initialized block
    typedef enum logic [MODE_W-1:0] {
        MODE_INACTIVE = 2'd0,
        MODE_ACTIVE   = 2'd1,
        MODE_DELAYED  = 2'd2,
        MODE_ALARMED  = 2'd3
    } mode_t;

    // Reported mode while not initialized
    localparam logic [OMODE_W-1:0] OMODE_UNINIT = 3'd4;

    // Input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 3'd0,
        CMD_PIN     = 3'd1,
        CMD_ENABLE  = 3'd2,
        CMD_DISABLE = 3'd3,
        CMD_INIT    = 3'd4,
        CMD_DESTROY = 3'd5
    } cmd_t;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_WATCHED_PIN = 2'd0;
    localparam logic [IDX_W-1:0] CFG_START_MODE  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_DELAY_SEC   = 2'd2;
    localparam logic [IDX_W-1:0] CFG_ALARM_SEC   = 2'd3;

    // Countdown timer operations
    typedef enum logic [2:0] {
        TMR_HOLD,
        TMR_START,
        TMR_DEC,
        TMR_STOP,
        TMR_STOP_CLEAR
    } timer_op_t;

    typedef struct packed {
        timer_op_t          op;
        logic [COUNT_W-1:0] value;
    } timer_ctrl_t;

    typedef struct packed {
        logic running;
        logic expire;
    } timer_stat_t;

    // Entry delay in ms: (seconds + 1) * 1000
    function automatic logic [COUNT_W-1:0] delay_period(input logic [SEC_W-1:0] sec);
        logic [COUNT_W-1:0] ext;
        begin
            ext = COUNT_W'(sec) + COUNT_W'(1);
            return ext * COUNT_W'(MS_PER_SECOND);
        end
    endfunction

    // Alarm duration in ms: seconds * 1000
    function automatic logic [COUNT_W-1:0] alarm_period(input logic [SEC_W-1:0] sec);
        logic [COUNT_W-1:0] ext;
        begin
            ext = COUNT_W'(sec);
            return ext * COUNT_W'(MS_PER_SECOND);
        end
    endfunction

endpackage

// File: sv/mad_timer.sv
// Millisecond countdown timer of the motion alarm controller.
// Depends on mad_pkg for the control and status structs.
module mad_timer
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mad_pkg::timer_ctrl_t ctrl,
    output mad_pkg::timer_stat_t stat
);
    import mad_pkg::*;

    logic               running_reg;
    logic               running_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    // Apply the requested operation
    always_comb
    begin
        running_next = running_reg;
        count_next   = count_reg;
        unique case (ctrl.op)
            TMR_HOLD:
            begin
            end
            TMR_START:
            begin
                running_next = 1'b1;
                count_next   = ctrl.value;
            end
            TMR_DEC:
            begin
                count_next = count_reg - COUNT_W'(1);
            end
            TMR_STOP:
            begin
                running_next = 1'b0;
            end
            TMR_STOP_CLEAR:
            begin
                running_next = 1'b0;
                count_next   = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            running_reg <= running_next;
            count_reg   <= count_next;
        end
    end

    // Expire on the tick that finds the count at zero or one
    assign stat.running = running_reg;
    assign stat.expire  = running_reg && (count_reg <= COUNT_W'(1));

endmodule

// File: sv/motion_alarm_delay_fsm.sv
// An accepted input item goes into the input register, and then its result into the result register.
// Throughput: one item per cycle while the result side does not stall; the input register and the result register
// form a two-stage pipe, and the mode update fits in the cycle between them.
// Reset: mode uninitialized, timer stopped, remembered level low, configuration registers 0.
// Configuration writes are taken at any time and apply to the items that advance after them.
module motion_alarm_delay_fsm
(
    input  logic                          clk,
    input  logic                          rst_n,
    // each configuration register takes the low bits of cfg_data
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mad_pkg::IDX_W-1:0]     cfg_index,
    input  logic [mad_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mad_pkg::S_DATA_W-1:0]  s_tdata,  // cmd[2:0], event_pin[6:3], pin_level[7]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mad_pkg::M_DATA_W-1:0]  m_tdata   // mode[2:0], alarm_raised[3], error[4], 0[7:5]
);
    import mad_pkg::*;

    // Configuration registers
    logic [PIN_W-1:0]   watched_pin_reg;
    logic [MODE_W-1:0]  start_mode_reg;
    logic [SEC_W-1:0]   delay_seconds_reg;
    logic [SEC_W-1:0]   alarm_seconds_reg;

    // Input stage
    logic               in_valid_reg;
    cmd_t               in_cmd_reg;
    logic [PIN_W-1:0]   in_pin_reg;
    logic               in_level_reg;

    // Controller state
    logic               init_reg;
    logic               init_next;
    mode_t              mode_reg;
    mode_t              mode_next;
    logic               level_reg;
    logic               level_next;

    // Result stage
    logic               out_valid_reg;
    logic [OMODE_W-1:0] out_mode_reg;
    logic               out_raised_reg;
    logic               out_error_reg;

    logic               advance;
    logic               raised;
    logic               err;
    timer_ctrl_t        tctrl;
    timer_stat_t        tstat;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            watched_pin_reg   <= '0;
            start_mode_reg    <= '0;
            delay_seconds_reg <= '0;
            alarm_seconds_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WATCHED_PIN: watched_pin_reg   <= cfg_data[PIN_W-1:0];
                CFG_START_MODE:  start_mode_reg    <= cfg_data[MODE_W-1:0];
                CFG_DELAY_SEC:   delay_seconds_reg <= cfg_data[SEC_W-1:0];
                CFG_ALARM_SEC:   alarm_seconds_reg <= cfg_data[SEC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Capture the input item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg   <= cmd_t'(s_tdata[2:0]);
            in_pin_reg   <= s_tdata[6:3];
            in_level_reg <= s_tdata[7];
        end
    end

    // Countdown timer
    mad_timer u_timer
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (tctrl),
        .stat  (tstat)
    );

    // Mode state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg  <= 1'b0;
            mode_reg  <= MODE_INACTIVE;
            level_reg <= 1'b0;
        end
        else
        begin
            init_reg  <= init_next;
            mode_reg  <= mode_next;
            level_reg <= level_next;
        end
    end

    // Next mode, timer operation and result flags for the staged item
    always_comb
    begin
        init_next   = init_reg;
        mode_next   = mode_reg;
        level_next  = level_reg;
        raised      = 1'b0;
        err         = 1'b0;
        tctrl.op    = TMR_HOLD;
        tctrl.value = delay_period(delay_seconds_reg);
        if (advance)
        begin
            unique case (in_cmd_reg)
                CMD_TICK:
                begin
                    if (init_reg && tstat.running)
                    begin
                        if (!tstat.expire)
                        begin
                            tctrl.op = TMR_DEC;
                        end
                        else if (mode_reg == MODE_DELAYED)
                        begin
                            mode_next   = MODE_ALARMED;
                            raised      = 1'b1;
                            tctrl.op    = TMR_START;
                            tctrl.value = alarm_period(alarm_seconds_reg);
                        end
                        else if (mode_reg == MODE_ALARMED)
                        begin
                            tctrl.op   = TMR_STOP_CLEAR;
                            level_next = in_level_reg;
                            mode_next  = MODE_ACTIVE;
                        end
                        else
                        begin
                            tctrl.op = TMR_STOP_CLEAR;
                        end
                    end
                end
                CMD_PIN:
                begin
                    if (init_reg && (in_pin_reg == watched_pin_reg) &&
                        (mode_reg == MODE_ACTIVE || mode_reg == MODE_DELAYED))
                    begin
                        level_next = in_level_reg;
                        if (!level_reg)
                        begin
                            tctrl.op  = TMR_START;
                            mode_next = MODE_DELAYED;
                        end
                        else
                        begin
                            tctrl.op  = TMR_STOP;
                            mode_next = MODE_ACTIVE;
                        end
                    end
                end
                CMD_ENABLE:
                begin
                    if (!init_reg)
                        err = 1'b1;
                    else
                        mode_next = MODE_ACTIVE;
                end
                CMD_DISABLE:
                begin
                    if (!init_reg)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_INACTIVE;
                        tctrl.op  = TMR_STOP;
                    end
                end
                CMD_INIT:
                begin
                    if (init_reg)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        init_next  = 1'b1;
                        level_next = 1'b0;
                        mode_next  = mode_t'(start_mode_reg);
                    end
                end
                CMD_DESTROY:
                begin
                    if (!init_reg)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_INACTIVE;
                        tctrl.op  = TMR_STOP;
                        init_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_mode_reg   <= init_next ? {1'b0, mode_next} : OMODE_UNINIT;
            out_raised_reg <= raised;
            out_error_reg  <= err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_error_reg, out_raised_reg, out_mode_reg};

endmodule

// File: sv/mad_check.sv
// Port-level checks for the motion alarm controller, bound to the top level.
// Depends on mad_pkg for mode codes and widths.
module mad_check
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mad_pkg::M_DATA_W-1:0]  m_tdata
);
    import mad_pkg::*;

    // A stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // A raised alarm reports alarmed mode and no error
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |->
            m_tdata[2:0] == {1'b0, MODE_ALARMED} && !m_tdata[4])
        else $error("alarm flagged outside alarmed mode");

    // Reported mode is a defined code and padding stays zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2] == 1'b0 || m_tdata[2:0] == OMODE_UNINIT) &&
                     m_tdata[7:5] == 3'b000)
        else $error("bad mode code or padding in result item");

    // An accepted item is followed by a valid result item
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("result item missing after accepted item");

endmodule

bind motion_alarm_delay_fsm mad_check u_mad_check
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/motion_alarm_delay_fsm_tb.sv
// Self-checking testbench for motion_alarm_delay_fsm: directed table, then random phases.
// Results are compared with an in-bench model of the alarm modes and the ms countdown.
// Depends on mad_pkg and the motion_alarm_delay_fsm RTL.
module motion_alarm_delay_fsm_tb;
    import mad_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int PIPE_LATENCY   = 4;
    localparam int END_SETTLE     = 12;
    localparam int STALL_LIMIT    = 4000;
    localparam int HOLD_CYCLES    = 200;
    localparam int RAND_PHASES    = 6;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int DIR_ROWS       = 33;

    // Codes the block has to ignore
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    // Reported modes of an initialized block
    localparam logic [OMODE_W-1:0] SHOW_INACTIVE = {1'b0, MODE_INACTIVE};
    localparam logic [OMODE_W-1:0] SHOW_ACTIVE   = {1'b0, MODE_ACTIVE};
    localparam logic [OMODE_W-1:0] SHOW_DELAYED  = {1'b0, MODE_DELAYED};
    localparam logic [OMODE_W-1:0] SHOW_ALARMED  = {1'b0, MODE_ALARMED};

    // Reported mode before initialize, sized for the table
    localparam logic [OMODE_W-1:0] SHOW_UNINIT_V = OMODE_UNINIT;

    typedef struct packed {
        logic               error;
        logic               raised;
        logic [OMODE_W-1:0] mode;
    } alarm_result_t;

    typedef struct packed {
        logic          typed;
        alarm_result_t want;
    } row_override_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [CMD_W-1:0]   code;     // command, or register index of a write
        logic [PIN_W-1:0]   pin;
        logic               level;
        logic [CFG_W-1:0]   value;    // register data of a write
        logic               typed;
        logic [OMODE_W-1:0] want_mode;
        logic               want_raised;
        logic               want_error;
    } step_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // cmd[2:0], event_pin[6:3], pin_level[7]
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // mode[2:0], alarm_raised[3], error[4], 0[7:5]

    // Model copy of the registers and the controller state
    logic [PIN_W-1:0]    reg_watched_pin;
    logic [MODE_W-1:0]   reg_start_mode;
    logic [SEC_W-1:0]    reg_delay_sec;
    logic [SEC_W-1:0]    reg_alarm_sec;
    logic                ctl_initialized;
    mode_t               ctl_mode;
    logic                ctl_level;
    logic                ctl_running;
    logic [COUNT_W-1:0]  ctl_countdown;

    alarm_result_t       pending_results[$];
    row_override_t       row_overrides[$];
    step_row_t           dir_rows [0:DIR_ROWS-1];
    int unsigned         mismatch_count = 0;
    int unsigned         quiet_cycles = 0;
    int unsigned         tx_quiet;
    logic                hold_request;

    motion_alarm_delay_fsm u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(12, 60);
    endfunction

    function automatic logic [COUNT_W-1:0] secs_to_ms(input int unsigned secs);
        return COUNT_W'(secs * MS_PER_SECOND);
    endfunction

    // Apply one item to the model state and return the result it reports
    function automatic alarm_result_t step_alarm_ctl(input logic [S_DATA_W-1:0] item);
        logic [CMD_W-1:0] c;
        logic [PIN_W-1:0] pin;
        logic             lvl;
        alarm_result_t    r;
        c   = item[2:0];
        pin = item[6:3];
        lvl = item[7];
        r   = '0;
        case (c)
            CMD_TICK:
            begin
                if (ctl_initialized && ctl_running)
                begin
                    if (ctl_countdown > COUNT_W'(1))
                    begin
                        ctl_countdown = ctl_countdown - COUNT_W'(1);
                    end
                    else if (ctl_mode == MODE_DELAYED)
                    begin
                        // entry delay over: sound the alarm and time it
                        ctl_mode      = MODE_ALARMED;
                        r.raised      = 1'b1;
                        ctl_countdown = secs_to_ms(int'(reg_alarm_sec));
                    end
                    else
                    begin
                        // alarm over: rearm from the pin; in other modes just stop
                        if (ctl_mode == MODE_ALARMED)
                        begin
                            ctl_level = lvl;
                            ctl_mode  = MODE_ACTIVE;
                        end
                        ctl_running   = 1'b0;
                        ctl_countdown = '0;
                    end
                end
            end
            CMD_PIN:
            begin
                if (ctl_initialized && pin == reg_watched_pin &&
                    (ctl_mode == MODE_ACTIVE || ctl_mode == MODE_DELAYED))
                begin
                    if (!ctl_level)
                    begin
                        ctl_countdown = secs_to_ms(int'(reg_delay_sec) + 1);
                        ctl_running   = 1'b1;
                        ctl_mode      = MODE_DELAYED;
                    end
                    else
                    begin
                        ctl_running = 1'b0;
                        ctl_mode    = MODE_ACTIVE;
                    end
                    ctl_level = lvl;
                end
            end
            CMD_ENABLE:
            begin
                if (!ctl_initialized) r.error = 1'b1;
                else ctl_mode = MODE_ACTIVE;
            end
            CMD_DISABLE:
            begin
                if (!ctl_initialized)
                begin
                    r.error = 1'b1;
                end
                else
                begin
                    ctl_mode    = MODE_INACTIVE;
                    ctl_running = 1'b0;
                end
            end
            CMD_INIT:
            begin
                if (ctl_initialized)
                begin
                    r.error = 1'b1;
                end
                else
                begin
                    ctl_initialized = 1'b1;
                    ctl_level       = 1'b0;
                    ctl_mode        = mode_t'(reg_start_mode);
                end
            end
            CMD_DESTROY:
            begin
                if (!ctl_initialized)
                begin
                    r.error = 1'b1;
                end
                else
                begin
                    ctl_mode        = MODE_INACTIVE;
                    ctl_running     = 1'b0;
                    ctl_initialized = 1'b0;
                end
            end
            default: ;
        endcase
        r.mode = ctl_initialized ? {1'b0, ctl_mode} : OMODE_UNINIT;
        return r;
    endfunction

    // Offer one item; return once it has been accepted
    task automatic send_item(input logic [CMD_W-1:0] c, input logic [PIN_W-1:0] pin,
                             input logic lvl, input logic typed, input alarm_result_t want);
        int unsigned gap;
        gap = 0;
        if (tx_quiet != 0) tx_quiet--;
        else if ($urandom_range(0, 99) == 0) tx_quiet = $urandom_range(20, 150);
        else if ($urandom_range(0, 3) == 0) gap = pick_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        row_overrides.push_back({typed, want});
        s_tvalid <= 1'b1;
        s_tdata  <= {lvl, pin, c};
        do @(posedge clk); while (!s_tready);
    endtask

    // Stop offering and wait until every result has come back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0 || row_overrides.size() != 0) @(negedge clk);
        repeat (PIPE_LATENCY) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_WATCHED_PIN: reg_watched_pin = val[PIN_W-1:0];
            CFG_START_MODE:  reg_start_mode  = val[MODE_W-1:0];
            CFG_DELAY_SEC:   reg_delay_sec   = val;
            CFG_ALARM_SEC:   reg_alarm_sec   = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] pin, input logic [CFG_W-1:0] start,
                            input logic [CFG_W-1:0] delay, input logic [CFG_W-1:0] alarm);
        write_reg(CFG_WATCHED_PIN, pin);
        write_reg(CFG_START_MODE, start);
        write_reg(CFG_DELAY_SEC, delay);
        write_reg(CFG_ALARM_SEC, alarm);
    endtask

    // Check each result item, then predict for each accepted input item
    always @(posedge clk)
    begin : score
        alarm_result_t want;
        alarm_result_t got;
        row_override_t ovr;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[4:0];
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result item, expected none, actual %h",
                             $time, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.mode !== want.mode)
                    begin
                        $display("%0t: mode expected %0d actual %0d",
                                 $time, want.mode, got.mode);
                        mismatch_count++;
                    end
                    if (got.raised !== want.raised)
                    begin
                        $display("%0t: alarm_raised expected %0b actual %0b",
                                 $time, want.raised, got.raised);
                        mismatch_count++;
                    end
                    if (got.error !== want.error)
                    begin
                        $display("%0t: error expected %0b actual %0b",
                                 $time, want.error, got.error);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = step_alarm_ctl(s_tdata);
                if (row_overrides.size() != 0)
                begin
                    ovr = row_overrides.pop_front();
                    if (ovr.typed) want = ovr.want;
                end
                pending_results.push_back(want);
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles == STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Drive m_tready: random stalls, calm stretches and one long hold on request
    initial
    begin : result_sink
        int unsigned stall_left;
        int unsigned calm_left;
        stall_left = 0;
        calm_left  = 0;
        m_tready   = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (calm_left != 0) calm_left--;
                else if ($urandom_range(0, 99) == 0) calm_left = $urandom_range(30, 200);
                else if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    initial
    begin : stimulus
        step_row_t        row;
        int unsigned      phase;
        int unsigned      n;
        int unsigned      pick;
        int unsigned      len;
        logic [CFG_W-1:0] p_pin;
        logic [CFG_W-1:0] p_start;
        logic [CFG_W-1:0] p_delay;
        logic [CFG_W-1:0] p_alarm;

        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        hold_request = 1'b0;
        tx_quiet     = 0;

        reg_watched_pin = '0;
        reg_start_mode  = '0;
        reg_delay_sec   = '0;
        reg_alarm_sec   = '0;
        ctl_initialized = 1'b0;
        ctl_mode        = MODE_INACTIVE;
        ctl_level       = 1'b0;
        ctl_running     = 1'b0;
        ctl_countdown   = '0;

        // kind, code, pin, level, value, typed, mode, raised, error
        dir_rows = '{
            '{ROW_ITEM, CMD_TICK,    4'd0,  1'b0, 8'd0,   1'b1, SHOW_UNINIT_V, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_PIN,     4'd0,  1'b1, 8'd0,   1'b1, SHOW_UNINIT_V, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_ENABLE,  4'd0,  1'b0, 8'd0,   1'b1, SHOW_UNINIT_V, 1'b0, 1'b1},
            '{ROW_ITEM, CMD_DISABLE, 4'd0,  1'b0, 8'd0,   1'b1, SHOW_UNINIT_V, 1'b0, 1'b1},
            '{ROW_ITEM, CMD_DESTROY, 4'd0,  1'b0, 8'd0,   1'b1, SHOW_UNINIT_V, 1'b0, 1'b1},
            '{ROW_ITEM, CMD_SPARE_6, 4'd15, 1'b1, 8'd0,   1'b1, SHOW_UNINIT_V, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_INIT,    4'd0,  1'b0, 8'd0,   1'b1, SHOW_INACTIVE, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_INIT,    4'd0,  1'b0, 8'd0,   1'b1, SHOW_INACTIVE, 1'b0, 1'b1},
            '{ROW_ITEM, CMD_PIN,     4'd0,  1'b1, 8'd0,   1'b1, SHOW_INACTIVE, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_ENABLE,  4'd0,  1'b0, 8'd0,   1'b1, SHOW_ACTIVE,   1'b0, 1'b0},
            '{ROW_ITEM, CMD_PIN,     4'd9,  1'b1, 8'd0,   1'b1, SHOW_ACTIVE,   1'b0, 1'b0},
            '{ROW_ITEM, CMD_PIN,     4'd0,  1'b1, 8'd0,   1'b1, SHOW_DELAYED,  1'b0, 1'b0},
            '{ROW_ITEM, CMD_PIN,     4'd0,  1'b0, 8'd0,   1'b0, SHOW_INACTIVE, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_PIN,     4'd0,  1'b1, 8'd0,   1'b0, SHOW_INACTIVE, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_DISABLE, 4'd0,  1'b0, 8'd0,   1'b0, SHOW_INACTIVE, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_ENABLE,  4'd0,  1'b0, 8'd0,   1'b0, SHOW_INACTIVE, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_DESTROY, 4'd0,  1'b0, 8'd0,   1'b1, SHOW_UNINIT_V, 1'b0, 1'b0},
            '{ROW_CFG,  CMD_W'(CFG_WATCHED_PIN), 4'd0, 1'b0, 8'd15,
              1'b0, SHOW_INACTIVE, 1'b0, 1'b0},
            '{ROW_CFG,  CMD_W'(CFG_START_MODE),  4'd0, 1'b0, 8'd3,
              1'b0, SHOW_INACTIVE, 1'b0, 1'b0},
            '{ROW_CFG,  CMD_W'(CFG_DELAY_SEC),   4'd0, 1'b0, 8'd255,
              1'b0, SHOW_INACTIVE, 1'b0, 1'b0},
            '{ROW_CFG,  CMD_W'(CFG_ALARM_SEC),   4'd0, 1'b0, 8'd255,
              1'b0, SHOW_INACTIVE, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_INIT,    4'd0,  1'b0, 8'd0,   1'b1, SHOW_ALARMED,  1'b0, 1'b0},
            '{ROW_ITEM, CMD_PIN,     4'd15, 1'b1, 8'd0,   1'b0, SHOW_INACTIVE, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_ENABLE,  4'd0,  1'b0, 8'd0,   1'b0, SHOW_INACTIVE, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_PIN,     4'd15, 1'b1, 8'd0,   1'b0, SHOW_INACTIVE, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_TICK,    4'd15, 1'b1, 8'd0,   1'b0, SHOW_INACTIVE, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_PIN,     4'd15, 1'b0, 8'd0,   1'b0, SHOW_INACTIVE, 1'b0, 1'b0},
            '{ROW_CFG,  CMD_W'(CFG_START_MODE),  4'd0, 1'b0, 8'd2,
              1'b0, SHOW_INACTIVE, 1'b0, 1'b0},
            '{ROW_CFG,  CMD_W'(CFG_DELAY_SEC),   4'd0, 1'b0, 8'd0,
              1'b0, SHOW_INACTIVE, 1'b0, 1'b0},
            '{ROW_CFG,  CMD_W'(CFG_ALARM_SEC),   4'd0, 1'b0, 8'd0,
              1'b0, SHOW_INACTIVE, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_DESTROY, 4'd0,  1'b0, 8'd0,   1'b1, SHOW_UNINIT_V, 1'b0, 1'b0},
            '{ROW_ITEM, CMD_INIT,    4'd0,  1'b0, 8'd0,   1'b1, SHOW_DELAYED,  1'b0, 1'b0},
            '{ROW_ITEM, CMD_TICK,    4'd3,  1'b0, 8'd0,   1'b0, SHOW_INACTIVE, 1'b0, 1'b0}
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: register writes only once the block has gone idle
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG)
            begin
                drain_results();
                write_reg(row.code[IDX_W-1:0], row.value);
            end
            else
            begin
                send_item(row.code, row.pin, row.level, row.typed,
                          {row.want_error, row.want_raised, row.want_mode});
            end
        end

        // Random phases, each under its own register setting
        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            drain_results();
            p_pin   = 8'($urandom_range(0, 15));
            p_start = 8'($urandom_range(0, 3));
            p_delay = 8'd0;
            p_alarm = 8'd0;
            case (phase)
                1: p_alarm = 8'd1;
                2:
                begin
                    p_start = 8'd1;
                    p_delay = 8'd1;
                end
                3:
                begin
                    p_delay = 8'($urandom_range(0, 2));
                    p_alarm = 8'($urandom_range(0, 2));
                end
                4:
                begin
                    p_pin   = 8'd0;
                    p_start = 8'd0;
                    p_delay = 8'd254;
                    p_alarm = 8'd255;
                end
                5: p_pin = 8'd15;
                default: ;
            endcase
            set_regs(p_pin, p_start, p_delay, p_alarm);

            // Hold the result side off while items keep coming, so the input stalls
            if (phase == 2)
            begin
                hold_request = 1'b1;
                tx_quiet     = 60;
            end

            n = 0;
            while (n < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                n++;
                if (pick < 6)
                begin
                    // short tick run: wear the countdown down
                    len = $urandom_range(8, 24);
                    n   = n + len - 1;
                    repeat (len) send_item(CMD_TICK, 4'($urandom_range(0, 15)),
                                           1'($urandom_range(0, 1)), 1'b0, '0);
                end
                else if (pick < 38)
                begin
                    send_item(CMD_TICK, 4'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1)), 1'b0, '0);
                end
                else if (pick < 66)
                begin
                    send_item(CMD_PIN, reg_watched_pin, 1'($urandom_range(0, 1)), 1'b0, '0);
                end
                else if (pick < 74)
                begin
                    send_item(CMD_PIN, 4'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1)), 1'b0, '0);
                end
                else if (pick < 82)
                begin
                    send_item(CMD_ENABLE, 4'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1)), 1'b0, '0);
                end
                else if (pick < 86)
                begin
                    send_item(CMD_DISABLE, 4'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1)), 1'b0, '0);
                end
                else if (pick < 93)
                begin
                    send_item(CMD_INIT, 4'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1)), 1'b0, '0);
                end
                else if (pick < 96)
                begin
                    send_item(CMD_DESTROY, 4'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1)), 1'b0, '0);
                end
                else
                begin
                    send_item(($urandom_range(0, 1) != 0) ? CMD_SPARE_7 : CMD_SPARE_6,
                              4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), 1'b0, '0);
                end
            end
        end

        drain_results();
        repeat (END_SETTLE) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/mad_pkg.sv
sv/mad_timer.sv
sv/motion_alarm_delay_fsm.sv
sv/mad_check.sv
tb/sv/motion_alarm_delay_fsm_tb.sv
